/* sv/tcc_pkg.sv */
package tcc_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int CELL_W  = 2 * BYTE_W;
    localparam int KIND_W  = 2;
    localparam int DATA_W  = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_COLOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_COLOR  = 1'd1;

    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] COLOR_ZERO   = 8'h00;

    localparam logic [BYTE_W-1:0] SCROLL_COLOR_RESET = 8'd3;
    localparam logic [BYTE_W-1:0] BLANK_COLOR_RESET  = 8'd0;

endpackage

/* sv/text_console_cursor_scroll.sv */
// Put (no scroll), unused kind and off-screen read: result registered at the accept edge,
// one word per cycle while m_tready is high. On-screen read: the cell is read into
// rd_data_reg, then the result is registered in ST_READ. Scroll and clear: one cell
// per cycle through the screen memory, then ST_DRAIN. Reset (aresetn low, synchronous):
// cursor to 0, colors to 3 and 0, then a clearing pass over all ROWS*COLUMNS cells and
// ST_DRAIN with s_tready low; configuration writes still taken.
module text_console_cursor_scroll #(
    parameter int COLUMNS = tcc_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcc_pkg::ROWS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // ch[7:0], color[15:8], col[22:16], row[27:23], zero fill
    input  logic [tcc_pkg::DATA_W-1:0]      s_tdata,
    // kind[1:0]
    input  logic [tcc_pkg::KIND_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // cell_char[7:0], cell_color[15:8], cursor_col[22:16], cursor_row[27:23],
    // scrolled[28], bad_position[29], zero fill
    output logic [tcc_pkg::DATA_W-1:0]      m_tdata,
    input  logic                            cfg_we,
    input  logic [tcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcc_pkg::BYTE_W-1:0]      cfg_wdata
);

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int MOVE_CELLS = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int WIDE_W     = tcc_pkg::ROW_W + tcc_pkg::COL_W + 1;
    localparam int COL_W      = tcc_pkg::COL_W;
    localparam int ROW_W      = tcc_pkg::ROW_W;
    localparam int BYTE_W     = tcc_pkg::BYTE_W;

    localparam logic [COL_W:0]    COLS_X   = (COL_W + 1)'(COLUMNS);
    localparam logic [ROW_W:0]    ROWS_Y   = (ROW_W + 1)'(ROWS);
    localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] MOVE_END = ADDR_W'(MOVE_CELLS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [tcc_pkg::CELL_W-1:0] screen_mem [0:CELLS-1];

    logic [1:0]         state_reg, state_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic               sweep_scroll_reg, sweep_scroll_next;
    logic               report_reg, report_next;
    logic [COL_W-1:0]   cursor_x_reg, cursor_x_next;
    logic [ROW_W-1:0]   cursor_y_reg, cursor_y_next;
    logic               wr_valid_reg, wr_valid_next;
    logic [ADDR_W-1:0]  wr_addr_reg, wr_addr_next;
    logic               wr_move_reg, wr_move_next;
    logic [BYTE_W-1:0]  scroll_color_reg;
    logic [BYTE_W-1:0]  blank_color_reg;
    logic [tcc_pkg::CELL_W-1:0] rd_data_reg;
    logic               out_valid_reg;
    logic [tcc_pkg::DATA_W-1:0] out_data_reg;

    logic [BYTE_W-1:0]  in_ch, in_color;
    logic [COL_W-1:0]   in_col;
    logic [ROW_W-1:0]   in_row;
    logic               accept;
    logic               rd_in_range;
    logic [ADDR_W-1:0]  rd_item_addr, cursor_addr, rd_addr;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [tcc_pkg::CELL_W-1:0] mem_wdata;
    logic               newline;
    logic [COL_W:0]     x_step;
    logic [ROW_W:0]     y_step;
    logic               need_scroll;
    logic               load_out;
    logic [BYTE_W-1:0]  out_char, out_color;
    logic               out_scrolled, out_bad;

    assign in_ch    = s_tdata[7:0];
    assign in_color = s_tdata[15:8];
    assign in_col   = s_tdata[22:16];
    assign in_row   = s_tdata[27:23];

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign rd_in_range  = ((COL_W + 1)'(in_col) < COLS_X) && ((ROW_W + 1)'(in_row) < ROWS_Y);
    assign rd_item_addr = rd_in_range
        ? ADDR_W'(WIDE_W'(in_row) * WIDE_W'(COLUMNS) + WIDE_W'(in_col)) : '0;
    assign cursor_addr  =
        ADDR_W'(WIDE_W'(cursor_y_reg) * WIDE_W'(COLUMNS) + WIDE_W'(cursor_x_reg));

    // cursor advance for a put
    always_comb begin
        newline = (in_ch == tcc_pkg::CHAR_NEWLINE);
        x_step  = newline ? '0 : (COL_W + 1)'(cursor_x_reg) + (COL_W + 1)'(1);
        y_step  = newline ? (ROW_W + 1)'(cursor_y_reg) + (ROW_W + 1)'(1)
                          : (ROW_W + 1)'(cursor_y_reg);
        if (x_step >= COLS_X) begin
            x_step = '0;
            y_step = y_step + (ROW_W + 1)'(1);
        end
        need_scroll = (y_step >= ROWS_Y);
    end

    always_comb begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        sweep_scroll_next = sweep_scroll_reg;
        report_next       = report_reg;
        cursor_x_next     = cursor_x_reg;
        cursor_y_next     = cursor_y_reg;
        wr_valid_next     = 1'b0;
        wr_addr_next      = idx_reg;
        wr_move_next      = 1'b0;
        load_out          = 1'b0;
        out_char          = '0;
        out_color         = '0;
        out_scrolled      = 1'b0;
        out_bad           = 1'b0;
        rd_addr           = ADDR_W'(WIDE_W'(idx_reg) + WIDE_W'(COLUMNS));
        mem_we            = wr_valid_reg;
        mem_waddr         = wr_addr_reg;
        if (wr_move_reg) begin
            mem_wdata = {scroll_color_reg, rd_data_reg[BYTE_W-1:0]};
        end else if (sweep_scroll_reg) begin
            mem_wdata = {blank_color_reg, tcc_pkg::CHAR_SPACE};
        end else begin
            mem_wdata = {tcc_pkg::COLOR_ZERO, tcc_pkg::CHAR_SPACE};
        end

        unique case (state_reg)
            ST_IDLE: begin
                rd_addr = rd_item_addr;
                if (accept) begin
                    case (s_tuser)
                        tcc_pkg::KIND_PUT: begin
                            if (!newline) begin
                                mem_we    = 1'b1;
                                mem_waddr = cursor_addr;
                                mem_wdata = {in_color, in_ch};
                            end
                            cursor_x_next = x_step[COL_W-1:0];
                            if (need_scroll) begin
                                cursor_y_next     = LAST_ROW;
                                state_next        = ST_SWEEP;
                                idx_next          = '0;
                                sweep_scroll_next = 1'b1;
                                report_next       = 1'b1;
                            end else begin
                                cursor_y_next = y_step[ROW_W-1:0];
                                load_out      = 1'b1;
                            end
                        end
                        tcc_pkg::KIND_CLEAR: begin
                            state_next        = ST_SWEEP;
                            idx_next          = '0;
                            sweep_scroll_next = 1'b0;
                            report_next       = 1'b1;
                        end
                        tcc_pkg::KIND_READ: begin
                            if (rd_in_range) begin
                                state_next = ST_READ;
                            end else begin
                                out_bad  = 1'b1;
                                load_out = 1'b1;
                            end
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                out_char   = rd_data_reg[BYTE_W-1:0];
                out_color  = rd_data_reg[2*BYTE_W-1:BYTE_W];
                load_out   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SWEEP: begin
                wr_valid_next = 1'b1;
                wr_move_next  = sweep_scroll_reg && (idx_reg < MOVE_END);
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            ST_DRAIN: begin
                out_scrolled = sweep_scroll_reg;
                load_out     = report_reg;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= screen_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_SWEEP;
            idx_reg          <= '0;
            sweep_scroll_reg <= 1'b0;
            report_reg       <= 1'b0;
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            wr_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            scroll_color_reg <= tcc_pkg::SCROLL_COLOR_RESET;
            blank_color_reg  <= tcc_pkg::BLANK_COLOR_RESET;
        end else begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            sweep_scroll_reg <= sweep_scroll_next;
            report_reg       <= report_next;
            cursor_x_reg     <= cursor_x_next;
            cursor_y_reg     <= cursor_y_next;
            wr_valid_reg     <= wr_valid_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    tcc_pkg::CFG_SCROLL_COLOR: scroll_color_reg <= cfg_wdata;
                    tcc_pkg::CFG_BLANK_COLOR:  blank_color_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        wr_addr_reg <= wr_addr_next;
        wr_move_reg <= wr_move_next;
        if (load_out) begin
            out_data_reg <= {2'b00, out_bad, out_scrolled, cursor_y_next, cursor_x_next,
                             out_color, out_char};
        end
    end

`ifndef ASSERT_OFF
    // result register is empty whenever a word is still being worked on
    a_busy_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !out_valid_reg)
        else $error("result pending while busy");

    a_wr_only_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_valid_reg |-> (state_reg == ST_SWEEP || state_reg == ST_DRAIN))
        else $error("sweep write outside sweep");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((COL_W + 1)'(cursor_x_reg) < COLS_X) && ((ROW_W + 1)'(cursor_y_reg) < ROWS_Y))
        else $error("cursor off screen");

    a_scroll_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg[28]) |-> (out_data_reg[27:23] == LAST_ROW))
        else $error("scroll result not on last row");

    a_scroll_starts_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == tcc_pkg::KIND_PUT && need_scroll)
            |=> (state_reg == ST_SWEEP && idx_reg == '0 && sweep_scroll_reg))
        else $error("scroll did not start sweep");
`endif

endmodule
